// ===== rtl/rsrb_pkg.sv =====
// Package for the sequence reorder buffer: constants, item structs and control structs.
package rsrb_pkg;

  // Slot count; the slot index is the low bits of the sequence number, so this is a power of two.
  localparam int SLOT_COUNT = 64;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

  localparam logic [16:0] LATE_WINDOW   = 17'd1024;
  localparam logic [15:0] AHEAD_LIMIT   = 16'hFFFF >> 1;
  localparam logic [15:0] TIMEOUT_RESET = 16'd100;

  typedef enum logic [1:0] {
    KIND_RELEASE   = 2'd0,
    KIND_LATE      = 2'd1,
    KIND_AHEAD     = 2'd2,
    KIND_COLLISION = 2'd3
  } kind_t;

  typedef struct packed {
    logic [15:0] seq;
    logic [15:0] packet_handle;
    logic [31:0] rx_time_ms;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] out_seq;
    logic [15:0] out_handle;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] seq;
    logic [15:0] handle;
    logic [31:0] rx;
  } slot_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;
    logic srch_start;
    logic srch_step;
    logic apply_tmo;
    logic rd_slot;
    logic drop_emit;
    logic slot_write;
    logic rel_rd;
    logic rel_take;
    logic rel_flush;
    logic clear_wait;
    logic rx_rd;
    logic rx_latch;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic timeout;
    logic srch_done;
    logic drop;
    logic match;
    logic rel_full;
    logic pend_v;
    logic out_free;
    logic empty;
    logic waiting;
  } sts_t;

endpackage

// ===== rtl/rsrb_ctrl.sv =====
// Controller state machine for the sequence reorder buffer.
module rsrb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rsrb_pkg::sts_t sts,
  output rsrb_pkg::cmd_t cmd
);
  import rsrb_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_TMO    = 12'b000000000010,
    S_SRCH   = 12'b000000000100,
    S_SAPPLY = 12'b000000001000,
    S_DRD    = 12'b000000010000,
    S_DCHK   = 12'b000000100000,
    S_RELRD  = 12'b000001000000,
    S_RELCHK = 12'b000010000000,
    S_RELEND = 12'b000100000000,
    S_FINAL  = 12'b001000000000,
    S_RXSET  = 12'b010000000000,
    S_SPARE  = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   final_mode_r, final_mode_nxt;

  always_comb begin
    state_nxt      = state_r;
    final_mode_nxt = final_mode_r;
    cmd            = '0;
    in_ready       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_TMO;
        end
      end
      S_TMO: begin
        if (sts.timeout) begin
          cmd.srch_start = 1'b1;
          final_mode_nxt = 1'b0;
          state_nxt      = S_SRCH;
        end else begin
          state_nxt = S_DRD;
        end
      end
      S_SRCH: begin
        cmd.srch_step = 1'b1;
        if (sts.srch_done) state_nxt = S_SAPPLY;
      end
      S_SAPPLY: begin
        if (final_mode_r) begin
          cmd.rx_rd = 1'b1;
          state_nxt = S_RXSET;
        end else begin
          cmd.apply_tmo = 1'b1;
          state_nxt     = S_DRD;
        end
      end
      S_DRD: begin
        cmd.rd_slot = 1'b1;
        state_nxt   = S_DCHK;
      end
      S_DCHK: begin
        if (sts.drop) begin
          if (sts.out_free) begin
            cmd.drop_emit = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          cmd.slot_write = 1'b1;
          state_nxt      = S_RELRD;
        end
      end
      S_RELRD: begin
        if (sts.rel_full) begin
          state_nxt = S_RELEND;
        end else begin
          cmd.rel_rd = 1'b1;
          state_nxt  = S_RELCHK;
        end
      end
      S_RELCHK: begin
        if (sts.match) begin
          if (!sts.pend_v || sts.out_free) begin
            cmd.rel_take = 1'b1;
            state_nxt    = S_RELRD;
          end
        end else begin
          state_nxt = S_RELEND;
        end
      end
      S_RELEND: begin
        if (!sts.pend_v) begin
          state_nxt = S_FINAL;
        end else if (sts.out_free) begin
          cmd.rel_flush = 1'b1;
          state_nxt     = S_FINAL;
        end
      end
      S_FINAL: begin
        if (sts.empty) begin
          cmd.clear_wait = 1'b1;
          state_nxt      = S_IDLE;
        end else if (sts.waiting) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.srch_start = 1'b1;
          final_mode_nxt = 1'b1;
          state_nxt      = S_SRCH;
        end
      end
      S_RXSET: begin
        cmd.rx_latch = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      final_mode_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      final_mode_r <= final_mode_nxt;
    end
  end

endmodule

// ===== rtl/rsrb_dp.sv =====
// Datapath for the sequence reorder buffer: slot store, search, checks and output register.
module rsrb_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data,
  input  rsrb_pkg::in_item_t  in_item,
  input  rsrb_pkg::cmd_t      cmd,
  output rsrb_pkg::sts_t      sts,
  output logic                out_valid,
  input  logic                out_ready,
  output rsrb_pkg::out_item_t out_item
);
  import rsrb_pkg::*;

  logic [15:0]           timeout_r;
  in_item_t              item_r;
  logic                  started_r;
  logic [15:0]           expected_r;
  logic                  waiting_r;
  logic [31:0]           wait_start_r;
  logic [SLOT_COUNT-1:0] slot_valid_r;
  slot_entry_t           mem [SLOT_COUNT];
  slot_entry_t           rdata_r;
  logic [CNT_W-1:0]      scnt_r;
  logic [IDX_W-1:0]      sidx_r;
  logic                  sok_r;
  logic                  best_found_r;
  logic [15:0]           best_seq_r;
  logic [IDX_W-1:0]      best_idx_r;
  logic                  pend_v_r;
  logic [15:0]           pend_seq_r;
  logic [15:0]           pend_handle_r;
  logic [CNT_W-1:0]      rel_cnt_r;
  logic                  out_valid_r;
  out_item_t             out_item_r;

  logic [IDX_W-1:0] raddr, seq_idx, exp_idx;
  logic             rd_en, late, ahead, coll, scan_more, load;
  kind_t            drop_kind;
  out_item_t        emit_item;
  logic [31:0]      elapsed;

  assign seq_idx   = item_r.seq[IDX_W-1:0];
  assign exp_idx   = expected_r[IDX_W-1:0];
  assign scan_more = scnt_r < CNT_W'(SLOT_COUNT);
  assign elapsed   = item_r.now_ms - wait_start_r;

  always_comb begin
    rd_en = 1'b1;
    raddr = seq_idx;
    priority if (cmd.srch_step) begin
      rd_en = scan_more;
      raddr = scnt_r[IDX_W-1:0];
    end else if (cmd.rel_rd) begin
      raddr = exp_idx;
    end else if (cmd.rx_rd) begin
      raddr = best_idx_r;
    end else begin
      rd_en = cmd.rd_slot;
    end
  end

  // Packet checks, made once the slot of the packet has been read.
  assign late  = (item_r.seq < expected_r) &&
                 ({1'b0, expected_r} < ({1'b0, item_r.seq} + LATE_WINDOW));
  assign ahead = !(item_r.seq < expected_r) && (expected_r != 16'd0) &&
                 ((item_r.seq - expected_r) > AHEAD_LIMIT);
  assign coll  = slot_valid_r[seq_idx] && (rdata_r.seq != item_r.seq);

  always_comb begin
    priority if (late)  drop_kind = KIND_LATE;
    else if (ahead)     drop_kind = KIND_AHEAD;
    else if (coll)      drop_kind = KIND_COLLISION;
    else                drop_kind = KIND_RELEASE;
  end

  always_comb begin
    emit_item = '{kind: KIND_RELEASE, out_seq: pend_seq_r, out_handle: pend_handle_r,
                  last: cmd.rel_flush};
    if (cmd.drop_emit)
      emit_item = '{kind: drop_kind, out_seq: item_r.seq,
                    out_handle: item_r.packet_handle, last: 1'b1};
  end

  assign load = cmd.drop_emit || cmd.rel_flush || (cmd.rel_take && pend_v_r);

  always_ff @(posedge clk) begin
    if (cmd.slot_write)
      mem[seq_idx] <= '{seq: item_r.seq, handle: item_r.packet_handle, rx: item_r.rx_time_ms};
    if (rd_en) rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) item_r <= in_item;
    if (load) out_item_r <= emit_item;
    if (cmd.rel_take) begin
      pend_seq_r    <= expected_r;
      pend_handle_r <= rdata_r.handle;
    end
    if (cmd.srch_step) sidx_r <= scnt_r[IDX_W-1:0];
    if (sok_r && (!best_found_r || rdata_r.seq < best_seq_r)) begin
      best_seq_r <= rdata_r.seq;
      best_idx_r <= sidx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r    <= TIMEOUT_RESET;
      started_r    <= 1'b0;
      expected_r   <= 16'd0;
      waiting_r    <= 1'b0;
      wait_start_r <= 32'd0;
      slot_valid_r <= '0;
      scnt_r       <= '0;
      sok_r        <= 1'b0;
      best_found_r <= 1'b0;
      pend_v_r     <= 1'b0;
      rel_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) timeout_r <= cfg_wr_data;
      if (cmd.latch_in) begin
        rel_cnt_r <= '0;
        if (!started_r) begin
          started_r  <= 1'b1;
          expected_r <= in_item.seq;
        end
      end
      if (cmd.srch_start) begin
        scnt_r       <= '0;
        sok_r        <= 1'b0;
        best_found_r <= 1'b0;
      end else begin
        if (cmd.srch_step) begin
          sok_r <= scan_more && slot_valid_r[scnt_r[IDX_W-1:0]];
          if (scan_more) scnt_r <= scnt_r + CNT_W'(1);
        end
        if (sok_r) begin
          if (!best_found_r || rdata_r.seq < best_seq_r) best_found_r <= 1'b1;
        end
      end
      if (cmd.apply_tmo) begin
        if (best_found_r) expected_r <= best_seq_r;
        waiting_r <= 1'b0;
      end
      if (cmd.slot_write) slot_valid_r[seq_idx] <= 1'b1;
      if (cmd.rel_take) begin
        slot_valid_r[exp_idx] <= 1'b0;
        expected_r            <= expected_r + 16'd1;
        rel_cnt_r             <= rel_cnt_r + CNT_W'(1);
        pend_v_r              <= 1'b1;
      end
      if (cmd.rel_flush) pend_v_r <= 1'b0;
      if (cmd.clear_wait) waiting_r <= 1'b0;
      if (cmd.rx_latch) begin
        waiting_r    <= 1'b1;
        wait_start_r <= rdata_r.rx;
      end
      if (load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign sts.timeout   = waiting_r && (elapsed > {16'd0, timeout_r});
  assign sts.srch_done = !scan_more;
  assign sts.drop      = drop_kind != KIND_RELEASE;
  assign sts.match     = slot_valid_r[exp_idx] && (rdata_r.seq == expected_r);
  assign sts.rel_full  = rel_cnt_r == CNT_W'(SLOT_COUNT);
  assign sts.pend_v    = pend_v_r;
  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.empty     = slot_valid_r == '0;
  assign sts.waiting   = waiting_r;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A release advances the expected number by exactly one.
  a_take_advances: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rel_take |=> expected_r == $past(expected_r) + 16'd1)
    else $error("release did not advance the expected number");

  // No held release may be left over when a new item is taken in.
  a_no_pending_at_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch_in |-> !pend_v_r)
    else $error("held release outstanding at item accept");

  // The output register is never overwritten while its item is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_valid_r || out_ready))
    else $error("output item overwritten before it was taken");

endmodule

// ===== rtl/rtp_sequence_reorder_buffer_unit.sv =====
// Top level of the RTP sequence reorder buffer: controller and datapath.
//
// Each input item carries a packet's sequence number, its handle, its receive
// time and the current time. The block answers with zero or more result items:
// in-order releases (kind 0) or a single drop (late, too far ahead or slot
// collision), the final result of an input item carrying last set.
// Both channels use valid/ready; an item moves when both are high. The block
// takes one input item at a time and accepts the next only when the previous
// one has finished. Each search for the smallest stored number walks all 64
// slots through the single slot memory read port; it runs when waiting starts
// and when the timeout fires. The timeout register may be written at any time
// the block is idle.
// Results leave through an output register, so the block keeps working while
// one result waits; if the receiver stalls with a second result ready, the
// controller holds in place until the register frees. A synchronous reset
// clears the slot valid bits, the timing state and the output register, and
// restores the timeout to 100 ms.
module rtp_sequence_reorder_buffer_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  rsrb_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output rsrb_pkg::out_item_t out_item
);
  import rsrb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller sequences each item through its checks, releases and searches.
  rsrb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the slot store, the expected number and the output register.
  rsrb_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_item     (in_item),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item)
  );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the RTP sequence reorder buffer unit.
`timescale 1ns / 100ps

module testbench;
  import rsrb_pkg::*;

  // Ports of the unit under test. In the predictor's slot store below, only entries marked present are ever read.
  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;

  rtp_sequence_reorder_buffer_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

  // Predictor state: our own copy of the buffer's store and timing.
  logic [15:0] tmo_ms;
  logic        held     [SLOT_COUNT];
  logic [15:0] held_seq [SLOT_COUNT];
  logic [15:0] held_hdl [SLOT_COUNT];
  logic [31:0] held_rx  [SLOT_COUNT];
  logic        seen_first;
  logic [15:0] next_seq;
  logic        in_wait;
  logic [31:0] wait_from;

  out_item_t   pending_results[$];
  int          errors;
  int          n_results;
  int          n_items;
  int          n_release;
  int          n_drop;
  longint      cycles;
  logic        draining;

  // Stimulus generator's view of the time base.
  logic [31:0] clock_ms;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Index of the held packet with the smallest number, or -1 when nothing is held.
  function automatic int lowest_held();
    int best;
    best = -1;
    for (int i = 0; i < SLOT_COUNT; i++)
      if (held[i] && (best < 0 || held_seq[i] < held_seq[best])) best = i;
    return best;
  endfunction

  task automatic clear_model();
    tmo_ms     = TIMEOUT_RESET;
    seen_first = 1'b0;
    next_seq   = '0;
    in_wait    = 1'b0;
    wait_from  = '0;
    for (int i = 0; i < SLOT_COUNT; i++) held[i] = 1'b0;
  endtask

  // Works out the releases or the drop that one packet causes and queues them.
  task automatic predict_reorder(input in_item_t it);
    kind_t       verdict;
    int          slot;
    int          low;
    int          e;
    int          made;
    out_item_t   r;
    verdict = KIND_RELEASE;
    made = 0;
    if (!seen_first) begin
      seen_first = 1'b1;
      next_seq   = it.seq;
    end
    // A wait that has run past the timeout skips to the smallest held number.
    if (in_wait && (it.now_ms - wait_from) > {16'd0, tmo_ms}) begin
      low = lowest_held();
      if (low >= 0) next_seq = held_seq[low];
      in_wait = 1'b0;
    end
    if (it.seq < next_seq) begin
      if ({1'b0, next_seq} < {1'b0, it.seq} + LATE_WINDOW) verdict = KIND_LATE;
    end else if (next_seq != 0 && (it.seq - next_seq) > AHEAD_LIMIT) begin
      verdict = KIND_AHEAD;
    end
    slot = it.seq % SLOT_COUNT;
    if (verdict == KIND_RELEASE && held[slot] && held_seq[slot] != it.seq)
      verdict = KIND_COLLISION;
    if (verdict != KIND_RELEASE) begin
      r.kind = verdict; r.out_seq = it.seq; r.out_handle = it.packet_handle; r.last = 1'b1;
      pending_results.push_back(r);
      return;
    end
    held[slot] = 1'b1; held_seq[slot] = it.seq;
    held_hdl[slot] = it.packet_handle; held_rx[slot] = it.rx_time_ms;
    while (made < SLOT_COUNT) begin
      e = next_seq % SLOT_COUNT;
      if (!held[e] || held_seq[e] != next_seq) break;
      r.kind = KIND_RELEASE; r.out_seq = next_seq; r.out_handle = held_hdl[e]; r.last = 1'b0;
      pending_results.push_back(r);
      made++;
      held[e]  = 1'b0;
      next_seq = next_seq + 16'd1;
    end
    if (made > 0) pending_results[pending_results.size() - 1].last = 1'b1;
    low = lowest_held();
    if (low < 0) begin
      in_wait = 1'b0;
    end else if (!in_wait) begin
      in_wait   = 1'b1;
      wait_from = held_rx[low];
    end
  endtask

  // Presents one item, waits a random gap first, and predicts it on acceptance.
  // Valid is left high after acceptance; the next call or the caller takes it down.
  task automatic send_packet(input logic [15:0] s, input logic [15:0] h,
                             input logic [31:0] rx, input logic [31:0] now);
    int gap;
    in_item_t it;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.seq = s; it.packet_handle = h; it.rx_time_ms = rx; it.now_ms = now;
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    predict_reorder(it);
    n_items++;
  endtask

  // Waits for every expected result, then lets the block settle before a register write.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    tmo_ms = v;
  endtask

  // Receiver: random stalls per result, with whole stretches of no stalling.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = draining ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13));
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result kind=%0d seq=%0d handle=%0d last=%0d", $time,
                 out_item.kind, out_item.out_seq, out_item.out_handle, out_item.last);
      end else begin
        if (out_item !== pending_results[0]) begin
          errors++;
          $display("%0t: mismatch expected kind=%0d seq=%0d handle=%0d last=%0d", $time,
                   pending_results[0].kind, pending_results[0].out_seq,
                   pending_results[0].out_handle, pending_results[0].last);
          $display("%0t:          actual   kind=%0d seq=%0d handle=%0d last=%0d", $time,
                   out_item.kind, out_item.out_seq, out_item.out_handle, out_item.last);
        end
        if (pending_results[0].kind == KIND_RELEASE) n_release++; else n_drop++;
        void'(pending_results.pop_front());
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // One row of the directed table; the expected result is typed in only for easy rows.
  typedef struct {
    logic [15:0] s;
    logic [15:0] h;
    logic [31:0] rx;
    logic [31:0] now;
    logic        typed;
    kind_t       k;
  } row_t;

  row_t dir_rows[$];
  row_t cur;
  logic [15:0] base;
  logic [15:0] burst_seq[$];
  int          n_burst;
  int          pick;
  logic [15:0] tmp;

  initial begin
    errors = 0; n_results = 0; n_items = 0; n_release = 0; n_drop = 0;
    cycles = 0; draining = 1'b0; clock_ms = 32'd1000;
    rst_n = 1'b0; cfg_wr_en = 1'b0; cfg_wr_data = '0;
    in_valid = 1'b0; in_item = '0;
    clear_model();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. The first packet sets the expected number and is released at once;
    // numbers just below it are late, far above it too far ahead, and same-slot
    // different numbers collide. A duplicate overwrites, an unreleasable packet gives nothing.
    dir_rows.push_back('{16'd0,     16'hFFFF, 32'd0,          32'd0,          1'b1, KIND_RELEASE});
    dir_rows.push_back('{16'd0,     16'h0000, 32'd1,          32'd1,          1'b1, KIND_LATE});
    dir_rows.push_back('{16'd65535, 16'hA5A5, 32'd2,          32'd2,          1'b0, KIND_RELEASE});
    dir_rows.push_back('{16'd3,     16'h1111, 32'd10,         32'd10,         1'b0, KIND_RELEASE});
    dir_rows.push_back('{16'd3,     16'h2222, 32'd11,         32'd11,         1'b0, KIND_RELEASE});
    dir_rows.push_back('{16'd67,    16'h3333, 32'd12,         32'd12,         1'b1, KIND_COLLISION});
    dir_rows.push_back('{16'd1,     16'h4444, 32'd13,         32'd13,         1'b0, KIND_RELEASE});
    dir_rows.push_back('{16'd2,     16'h5555, 32'd14,         32'd14,         1'b0, KIND_RELEASE});
    dir_rows.push_back('{16'd40000, 16'h6666, 32'd15,         32'd15,         1'b1, KIND_AHEAD});
    dir_rows.push_back('{16'd32771, 16'h7777, 32'd16,         32'd16,         1'b0, KIND_RELEASE});
    dir_rows.push_back('{16'd10,    16'h8888, 32'hFFFF_FF00,  32'hFFFF_FF00,  1'b0, KIND_RELEASE});
    // The wait clock wraps through zero here before the timeout fires.
    dir_rows.push_back('{16'd12,    16'h9999, 32'hFFFF_FF10,  32'h0000_0020,  1'b0, KIND_RELEASE});
    dir_rows.push_back('{16'd9,     16'hAAAA, 32'h0000_0100,  32'h0000_0100,  1'b1, KIND_LATE});
    dir_rows.push_back('{16'd13,    16'hBBBB, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b0, KIND_RELEASE});
    foreach (dir_rows[i]) begin
      cur = dir_rows[i];
      send_packet(cur.s, cur.h, cur.rx, cur.now);
      if (cur.typed && pending_results[pending_results.size() - 1].kind != cur.k) begin
        errors++;
        $display("%0t: directed row %0d expected kind %0d, predicted %0d", $time, i,
                 cur.k, pending_results[pending_results.size() - 1].kind);
      end
    end

    // Random part in phases with different timeouts, the extremes among them.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_timeout(16'd0);
        1: write_timeout(16'd60000);
        2: write_timeout(16'hFFFF);
        3: write_timeout(16'd5);
        default: write_timeout(16'd100);
      endcase
      // Make the store empty and restart from a random base by timeout skips.
      base = 16'($urandom_range(1, 65535));
      for (int n = 0; n < 15; n++) begin
        // Mostly bursts of nearby numbers in shuffled order with advancing time.
        n_burst = $urandom_range(1, 8);
        burst_seq.delete();
        for (int j = 0; j < n_burst; j++) burst_seq.push_back(base + 16'(j));
        for (int j = n_burst - 1; j > 0; j--) begin
          pick = $urandom_range(0, j);
          tmp = burst_seq[j]; burst_seq[j] = burst_seq[pick]; burst_seq[pick] = tmp;
        end
        foreach (burst_seq[j]) begin
          clock_ms = clock_ms + $urandom_range(0, 40);
          case ($urandom_range(0, 9))
            0: send_packet(16'($urandom), 16'($urandom), $urandom, $urandom);
            1: send_packet(burst_seq[j] - 16'($urandom_range(1, 1100)), 16'($urandom),
                           clock_ms, clock_ms);
            2: send_packet(burst_seq[j] + 16'd64, 16'($urandom), clock_ms, clock_ms);
            3: send_packet(burst_seq[j] + 16'($urandom_range(32760, 32800)), 16'($urandom),
                           clock_ms, clock_ms);
            default: if ($urandom_range(0, 5) != 0)
              send_packet(burst_seq[j], 16'($urandom), clock_ms - $urandom_range(0, 20),
                          clock_ms);
          endcase
        end
        base = base + 16'(n_burst);
        if ($urandom_range(0, 12) == 0) base = base + 16'($urandom_range(1, 30));
        // Once per phase let the sender wait for every result before going on.
        if (n == 7) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending_results.size() != 0) @(posedge clk);
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    draining = 1'b1;
    repeat (300) @(posedge clk);
    $display("Covered %0d packets and %0d results under five timeout settings: %0d releases, %0d drops.",
             n_items, n_results, n_release, n_drop);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rsrb_pkg.sv
rtl/rsrb_ctrl.sv
rtl/rsrb_dp.sv
rtl/rtp_sequence_reorder_buffer_unit.sv
dv/testbench.sv
